// ===== design/csrs_pkg.sv =====
// package for the byte store with remove-all and search
// holds store geometry and action codes; no dependencies
`default_nettype none

package csrs_pkg;

    localparam int DEPTH  = 4096;
    localparam int ADDR_W = 12;
    localparam int CNT_W  = 13;
    localparam int DATA_W = 8;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_RANGE  = 3'd3,
        ACT_BINARY = 3'd4,
        ACT_READ   = 3'd5,
        ACT_WRITE  = 3'd6,
        ACT_NOP    = 3'd7
    } t_action;

endpackage

`default_nettype wire

// ===== design/char_store_remove_search_top.sv =====
// byte store top level: remove-all, range and binary search; uses csrs_pkg and csrs_ram
// append, clear, write, misses of the filled part answer next cycle; read passes S_READ
// range search reads from lo up to clamped hi until a match; remove-all compacts the filled part
// binary search: each probe passes S_BS_PROBE and S_BS_CMP; results cannot be stalled
// one transfer at a time, the next accepted in the cycle its result shows
// reset clears the fill count and control only; the store contents are not cleared
`default_nettype none

module char_store_remove_search_top
    import csrs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        i_action,
    input  wire logic [DATA_W-1:0] i_ch,
    input  wire logic [ADDR_W-1:0] i_index_lo,
    input  wire logic [ADDR_W-1:0] i_index_hi,
    output logic                   o_valid,
    output logic [CNT_W-1:0]       o_fill_count,
    output logic                   o_found,
    output logic [ADDR_W-1:0]      o_position,
    output logic [DATA_W-1:0]      o_read_byte,
    output logic [CNT_W-1:0]       o_removed_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_BS_PROBE,
        S_BS_CMP
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_fill;
    logic [DATA_W-1:0]   r_key;
    logic                r_op_rm;
    logic [ADDR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]   r_end;
    logic                r_issue;
    logic                r_chk_v;
    logic [ADDR_W-1:0]   r_chk_a;
    logic                r_chk_last;
    logic [CNT_W-1:0]    r_wr;
    logic [CNT_W-1:0]    r_gone;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_ub;
    logic [ADDR_W-1:0]   r_mid;

    logic                accept;
    logic [CNT_W-1:0]    fill_m1;
    logic [ADDR_W-1:0]   hi_clamp;
    logic                range_empty;
    logic                lo_in_fill;
    logic                has_room;
    logic [CNT_W:0]      bs_sum;
    logic [ADDR_W-1:0]   bs_mid;
    logic                chk_keep;
    logic [CNT_W-1:0]    n_wr;
    logic [CNT_W-1:0]    n_gone;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // bounds against the fill count
    assign fill_m1     = r_fill - CNT_W'(1);
    assign hi_clamp    = ({1'b0, i_index_hi} > fill_m1) ? fill_m1[ADDR_W-1:0] : i_index_hi;
    assign range_empty = (r_fill == '0) || (i_index_lo > hi_clamp);
    assign lo_in_fill  = ({1'b0, i_index_lo} < r_fill);
    assign has_room    = (r_fill < CNT_W'(DEPTH));

    // binary search midpoint over the half-open window [lo, ub)
    assign bs_sum = {1'b0, r_lo} + {1'b0, r_ub} - (CNT_W + 1)'(1);
    assign bs_mid = bs_sum[ADDR_W:1];

    // compaction bookkeeping for the byte under check
    assign chk_keep = (ram_rdata != r_key);
    assign n_wr     = chk_keep ? r_wr + CNT_W'(1) : r_wr;
    assign n_gone   = chk_keep ? r_gone : r_gone + CNT_W'(1);

    // read address select
    always_comb begin
        case (r_state)
            S_SCAN:     ram_raddr = r_ptr;
            S_BS_PROBE: ram_raddr = bs_mid;
            default:    ram_raddr = i_index_lo;
        endcase
    end

    // write port: append and write from idle, compaction during remove-all
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_index_lo;
        ram_wdata = i_ch;
        if (r_state == S_IDLE) begin
            if (accept && i_action == ACT_APPEND && has_room) begin
                ram_we    = 1'b1;
                ram_waddr = r_fill[ADDR_W-1:0];
            end else if (accept && i_action == ACT_WRITE && lo_in_fill) begin
                ram_we = 1'b1;
            end
        end else if (r_state == S_SCAN && r_op_rm && r_chk_v && chk_keep) begin
            ram_we    = 1'b1;
            ram_waddr = r_wr[ADDR_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    csrs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, fill count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            o_valid <= 1'b0;
            r_issue <= 1'b0;
            r_chk_v <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key           <= i_ch;
                        o_fill_count    <= r_fill;
                        o_found         <= 1'b0;
                        o_position      <= '0;
                        o_read_byte     <= '0;
                        o_removed_count <= '0;
                        case (t_action'(i_action))
                            ACT_APPEND: begin
                                o_valid <= 1'b1;
                                if (has_room) begin
                                    r_fill       <= r_fill + CNT_W'(1);
                                    o_fill_count <= r_fill + CNT_W'(1);
                                end
                            end
                            ACT_CLEAR: begin
                                o_valid      <= 1'b1;
                                r_fill       <= '0;
                                o_fill_count <= '0;
                            end
                            ACT_REMOVE: begin
                                if (r_fill == '0) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_op_rm <= 1'b1;
                                    r_ptr   <= '0;
                                    r_end   <= fill_m1[ADDR_W-1:0];
                                    r_issue <= 1'b1;
                                    r_chk_v <= 1'b0;
                                    r_wr    <= '0;
                                    r_gone  <= '0;
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_RANGE: begin
                                if (range_empty) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_op_rm <= 1'b0;
                                    r_ptr   <= i_index_lo;
                                    r_end   <= hi_clamp;
                                    r_issue <= 1'b1;
                                    r_chk_v <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            ACT_BINARY: begin
                                if (r_fill == '0) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_lo    <= '0;
                                    r_ub    <= r_fill;
                                    r_state <= S_BS_PROBE;
                                end
                            end
                            ACT_READ: begin
                                if (lo_in_fill) begin
                                    r_state <= S_READ;
                                end else begin
                                    o_valid <= 1'b1;
                                end
                            end
                            default: begin
                                o_valid <= 1'b1;
                            end
                        endcase
                    end
                end

                S_READ: begin
                    o_valid     <= 1'b1;
                    o_found     <= 1'b1;
                    o_read_byte <= ram_rdata;
                    r_state     <= S_IDLE;
                end

                S_SCAN: begin
                    // issue side: one read per cycle up to the end index
                    if (r_issue) begin
                        r_chk_v    <= 1'b1;
                        r_chk_a    <= r_ptr;
                        r_chk_last <= (r_ptr == r_end);
                        if (r_ptr == r_end) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr + ADDR_W'(1);
                        end
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                    // check side: data of the address issued in the previous cycle
                    if (r_chk_v) begin
                        if (r_op_rm) begin
                            r_wr   <= n_wr;
                            r_gone <= n_gone;
                            if (r_chk_last) begin
                                o_valid         <= 1'b1;
                                r_fill          <= n_wr;
                                o_fill_count    <= n_wr;
                                o_removed_count <= n_gone;
                                r_issue         <= 1'b0;
                                r_state         <= S_IDLE;
                            end
                        end else if (!chk_keep) begin
                            o_valid    <= 1'b1;
                            o_found    <= 1'b1;
                            o_position <= r_chk_a;
                            r_issue    <= 1'b0;
                            r_state    <= S_IDLE;
                        end else if (r_chk_last) begin
                            o_valid <= 1'b1;
                            r_issue <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_BS_PROBE: begin
                    if (r_lo >= r_ub) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_mid   <= bs_mid;
                        r_state <= S_BS_CMP;
                    end
                end

                S_BS_CMP: begin
                    if (ram_rdata == r_key) begin
                        o_valid    <= 1'b1;
                        o_found    <= 1'b1;
                        o_position <= r_mid;
                        r_state    <= S_IDLE;
                    end else begin
                        if (r_key < ram_rdata) begin
                            r_ub <= {1'b0, r_mid};
                        end else begin
                            r_lo <= {1'b0, r_mid} + CNT_W'(1);
                        end
                        r_state <= S_BS_PROBE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result never shows while the block still reports busy
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // fill count never exceeds the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // a clear transfer answers in the next cycle with an empty store
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_CLEAR) |=> (o_valid && o_fill_count == '0))
        else $error("clear did not report an empty store");

    // removed plus remaining bytes never exceed the store depth on any result
    a_remove_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_fill_count} + {1'b0, o_removed_count} <= (CNT_W + 1)'(DEPTH)))
        else $error("removed plus remaining exceeds depth");
`endif

endmodule

`default_nettype wire

// ===== design/csrs_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module csrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
